@@ sv/jdq_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick direction quantizer package
// Shared constants, direction and register codes, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package jdq_pkg;

  localparam int PRESCALE = 8;
  localparam int ZW       = 30;
  localparam int NW       = 30;
  localparam int QW       = 16;
  localparam int DVW      = 29;

  localparam logic [2:0] DIR_FREE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;
  localparam logic [2:0] DIR_LEFT  = 3'd4;

  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_SNAP     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [11:0] DEADZONE_RESET = 12'd50;
  localparam logic [5:0]  SNAP_RESET     = 6'd8;
  localparam logic [15:0] INTERVAL_RESET = 16'd500;

  localparam logic signed [ZW-1:0] Z_HALF_TURN = 30'sd180000000;
  localparam logic signed [NW:0]   N_OFFSET    = 31'sd270005000;
  localparam logic [NW-1:0]        N_WRAP      = 30'd360005000;
  localparam logic [NW-1:0]        FULL_TURN   = 30'd360000000;
  localparam logic [DVW-1:0]       DIV_TOP     = 29'd327680000;
  localparam logic [QW-1:0]        ANGLE_FULL  = 16'd36000;

  localparam logic [16:0] CD_FULL  = 17'd36000;
  localparam logic [16:0] CD_RIGHT = 17'd9000;
  localparam logic [16:0] CD_DOWN  = 17'd18000;
  localparam logic [16:0] CD_LEFT  = 17'd27000;

  function automatic logic [ZW-1:0] atan_udeg(input logic [4:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 30'd45000000;
      5'd1:    v = 30'd26565051;
      5'd2:    v = 30'd14036243;
      5'd3:    v = 30'd7125016;
      5'd4:    v = 30'd3576334;
      5'd5:    v = 30'd1789911;
      5'd6:    v = 30'd895174;
      5'd7:    v = 30'd447614;
      5'd8:    v = 30'd223811;
      5'd9:    v = 30'd111906;
      5'd10:   v = 30'd55953;
      5'd11:   v = 30'd27976;
      5'd12:   v = 30'd13988;
      5'd13:   v = 30'd6994;
      5'd14:   v = 30'd3497;
      5'd15:   v = 30'd1749;
      5'd16:   v = 30'd874;
      5'd17:   v = 30'd437;
      5'd18:   v = 30'd219;
      5'd19:   v = 30'd109;
      5'd20:   v = 30'd55;
      5'd21:   v = 30'd27;
      5'd22:   v = 30'd14;
      5'd23:   v = 30'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/jdq_if.sv @@
// ----------------------------------------------------------------------------
// Joystick direction quantizer channels
// Valid/ready channels for input samples and for quantized results.
// ----------------------------------------------------------------------------
interface jdq_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic                   button_level;
  logic [31:0]            time_ms;

  modport source (output valid, x_sample, y_sample, button_level, time_ms, input ready);
  modport sink (input valid, x_sample, y_sample, button_level, time_ms, output ready);
endinterface

interface jdq_out_if;
  logic        valid;
  logic        ready;
  logic        is_centred;
  logic [2:0]  direction;
  logic [15:0] angle_centideg;
  logic        send_now;

  modport source (output valid, is_centred, direction, angle_centideg, send_now, input ready);
  modport sink (input valid, is_centred, direction, angle_centideg, send_now, output ready);
endinterface

@@ sv/joystick_direction_quantizer.sv @@
// ----------------------------------------------------------------------------
// Joystick direction quantizer
// Deadzone test, CORDIC angle, cardinal snap and rate-limited change report.
// ----------------------------------------------------------------------------
// An accepted sample gets the deadzone test; an off-centre one then passes
// the one-step-per-cycle CORDIC and the bit-serial divide by 10000 that
// rounds to centidegrees, and a centred one goes straight to the result.
// The next sample is taken only after the result is loaded, and loading
// waits while an earlier result is held and not taken. Reset restores the
// register defaults, mid-scale centre and send history and empties the result.
module joystick_direction_quantizer #(
  parameter int SAMPLE_BITS  = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  jdq_in_if.sink      sample,
  jdq_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int MW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = SAMPLE_BITS'(((1 << SAMPLE_BITS) - 1) / 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [11:0] deadzone;
  logic [5:0] snap_deg;
  logic [15:0] interval;
  logic [SAMPLE_BITS-1:0] centre_x;
  logic [SAMPLE_BITS-1:0] centre_y;
  logic prev_button;
  logic [31:0] last_send_time;
  logic [15:0] last_sent_angle;
  logic sent_valid;
  logic [SAMPLE_BITS-1:0] x_s;
  logic [SAMPLE_BITS-1:0] y_s;
  logic [31:0] t_s;
  logic centred;

  logic out_valid;
  logic out_centred;
  logic [2:0] out_dir;
  logic [15:0] out_angle;
  logic out_send;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0] mag_x;
  logic [DW-1:0] mag_y;
  logic centred_now;
  logic cordic_start;
  logic cordic_done;
  logic signed [jdq_pkg::ZW-1:0] z;
  logic div_done;
  logic [15:0] raw_angle;
  logic [15:0] snap_angle;
  logic [2:0] snap_dir;
  logic [31:0] elapsed;
  logic cfg_write;
  logic fin_load;
  logic due;

  assign dx = $signed({1'b0, centre_x}) - $signed({1'b0, x_s});
  assign dy = $signed({1'b0, centre_y}) - $signed({1'b0, y_s});
  assign mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign centred_now = (MW'(mag_x[SAMPLE_BITS-1:0]) <= MW'(deadzone))
                    && (MW'(mag_y[SAMPLE_BITS-1:0]) <= MW'(deadzone));
  assign cordic_start = (state == S_PREP) && !centred_now;

  jdq_cordic #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_start),
    .dx   (dx),
    .dy   (dy),
    .done (cordic_done),
    .z    (z)
  );

  jdq_cdiv u_cdiv (
    .clk  (clk),
    .rst  (rst),
    .start(cordic_done),
    .z    (z),
    .done (div_done),
    .angle(raw_angle)
  );

  jdq_snap u_snap (
    .angle_in (raw_angle),
    .snap_deg (snap_deg),
    .angle_out(snap_angle),
    .dir      (snap_dir)
  );

  assign elapsed   = t_s - last_send_time;
  assign due       = elapsed >= 32'(interval);
  assign fin_load  = (state == S_FIN) && (!out_valid || result.ready);
  assign cfg_write = psel && penable && pwrite;

  assign sample.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.is_centred     = out_centred;
  assign result.direction      = out_dir;
  assign result.angle_centideg = out_angle;
  assign result.send_now       = out_send;
  assign pready                = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      jdq_pkg::REG_DEADZONE: prdata = 32'(deadzone);
      jdq_pkg::REG_SNAP:     prdata = 32'(snap_deg);
      jdq_pkg::REG_INTERVAL: prdata = 32'(interval);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= jdq_pkg::DEADZONE_RESET;
      snap_deg <= jdq_pkg::SNAP_RESET;
      interval <= jdq_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        jdq_pkg::REG_DEADZONE: deadzone <= pwdata[11:0];
        jdq_pkg::REG_SNAP:     snap_deg <= pwdata[5:0];
        jdq_pkg::REG_INTERVAL: interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      centre_x        <= CENTRE_RESET;
      centre_y        <= CENTRE_RESET;
      prev_button     <= 1'b0;
      last_send_time  <= '0;
      last_sent_angle <= '0;
      sent_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            x_s         <= sample.x_sample;
            y_s         <= sample.y_sample;
            t_s         <= sample.time_ms;
            prev_button <= sample.button_level;
            if (sample.button_level && !prev_button) begin
              centre_x <= sample.x_sample;
              centre_y <= sample.y_sample;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          centred <= centred_now;
          state   <= centred_now ? S_FIN : S_CORD;
        end
        S_CORD: begin
          if (cordic_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_centred <= centred;
            state       <= S_IDLE;
            if (centred) begin
              out_dir   <= jdq_pkg::DIR_FREE;
              out_angle <= '0;
              out_send  <= 1'b0;
            end else begin
              out_dir   <= snap_dir;
              out_angle <= snap_angle;
              out_send  <= due && (!sent_valid || snap_angle != last_sent_angle);
              if (due) begin
                last_send_time <= t_s;
                if (!sent_valid || snap_angle != last_sent_angle) begin
                  last_sent_angle <= snap_angle;
                  sent_valid      <= 1'b1;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_PREP))
    else $error("accepted sample did not start processing");

  a_centred_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_centred) |->
      (result.angle_centideg == 16'd0 && result.direction == jdq_pkg::DIR_FREE
       && !result.send_now))
    else $error("centred result carries an angle or a report");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.angle_centideg < jdq_pkg::ANGLE_FULL))
    else $error("angle out of range");

  a_single_unit_busy: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == S_CORD))
    else $error("CORDIC finished outside its phase");

endmodule

@@ sv/jdq_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// One rotation step per cycle; accumulates the angle in microdegrees.
// ----------------------------------------------------------------------------
module jdq_cordic #(
  parameter int SAMPLE_BITS  = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SAMPLE_BITS:0]         dx,
  input  logic signed [SAMPLE_BITS:0]         dy,
  output logic                                done,
  output logic signed [jdq_pkg::ZW-1:0]       z
);

  localparam int XW = SAMPLE_BITS + jdq_pkg::PRESCALE + 3;
  localparam int CW = $clog2(CORDIC_STEPS);

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [jdq_pkg::ZW-1:0] step_angle;
  logic [CW-1:0] cnt;
  logic busy;

  assign x0 = XW'(dx) <<< jdq_pkg::PRESCALE;
  assign y0 = XW'(dy) <<< jdq_pkg::PRESCALE;
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign step_angle = $signed(jdq_pkg::atan_udeg(5'(cnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        if (dx[SAMPLE_BITS]) begin
          x <= -x0;
          y <= -y0;
          z <= jdq_pkg::Z_HALF_TURN;
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end else if (busy) begin
        if (!y[XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + step_angle;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - step_angle;
        end
        if (cnt == CW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/jdq_cdiv.sv @@
// ----------------------------------------------------------------------------
// Angle rotation and centidegree rounding
// Turns the angle so that up is zero and divides by 10000 one bit per cycle.
// ----------------------------------------------------------------------------
module jdq_cdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [jdq_pkg::ZW-1:0] z,
  output logic                          done,
  output logic [jdq_pkg::QW-1:0]        angle
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RED  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0] phase;
  logic [3:0] cnt;
  logic [jdq_pkg::NW-1:0] rem;
  logic [jdq_pkg::DVW-1:0] dvs;
  logic [jdq_pkg::QW-1:0] q;
  logic signed [jdq_pkg::NW:0] sum;
  logic fits;

  assign sum   = (jdq_pkg::NW + 1)'(z) + jdq_pkg::N_OFFSET;
  assign fits  = rem >= jdq_pkg::NW'(dvs);
  assign angle = (q >= jdq_pkg::ANGLE_FULL) ? q - jdq_pkg::ANGLE_FULL : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            rem   <= sum[jdq_pkg::NW-1:0];
            phase <= P_RED;
          end
        end
        P_RED: begin
          if (rem >= jdq_pkg::N_WRAP) begin
            rem <= rem - jdq_pkg::FULL_TURN;
          end
          dvs   <= jdq_pkg::DIV_TOP;
          q     <= '0;
          cnt   <= '0;
          phase <= P_DIV;
        end
        P_DIV: begin
          if (fits) begin
            rem <= rem - jdq_pkg::NW'(dvs);
          end
          q   <= {q[jdq_pkg::QW-2:0], fits};
          dvs <= dvs >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

@@ sv/jdq_snap.sv @@
// ----------------------------------------------------------------------------
// Cardinal snap
// Snaps an angle lying strictly within the window of a cardinal onto it.
// ----------------------------------------------------------------------------
module jdq_snap (
  input  logic [15:0] angle_in,
  input  logic [5:0]  snap_deg,
  output logic [15:0] angle_out,
  output logic [2:0]  dir
);

  logic [16:0] a;
  logic [16:0] w;

  assign a = 17'(angle_in);
  assign w = 17'(snap_deg) * 17'd100;

  always_comb begin
    priority if (a > jdq_pkg::CD_FULL - w || a < w) begin
      angle_out = '0;
      dir       = jdq_pkg::DIR_UP;
    end else if (a > jdq_pkg::CD_RIGHT - w && a < jdq_pkg::CD_RIGHT + w) begin
      angle_out = 16'(jdq_pkg::CD_RIGHT);
      dir       = jdq_pkg::DIR_RIGHT;
    end else if (a > jdq_pkg::CD_DOWN - w && a < jdq_pkg::CD_DOWN + w) begin
      angle_out = 16'(jdq_pkg::CD_DOWN);
      dir       = jdq_pkg::DIR_DOWN;
    end else if (a > jdq_pkg::CD_LEFT - w && a < jdq_pkg::CD_LEFT + w) begin
      angle_out = 16'(jdq_pkg::CD_LEFT);
      dir       = jdq_pkg::DIR_LEFT;
    end else begin
      angle_out = angle_in;
      dir       = jdq_pkg::DIR_FREE;
    end
  end

endmodule

@@ tb/tb_joystick_direction_quantizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joystick direction quantizer testbench
// Drives directed and random samples through the sample channel under random
// sender bursts and receiver stalls, reprograms the registers between phases,
// and checks every result against an in-bench angle and send-flag predictor.
// ----------------------------------------------------------------------------
module tb_joystick_direction_quantizer;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        is_centred;
    logic [2:0]  direction;
    logic [15:0] angle_centideg;
    logic        send_now;
  } quant_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic        btn;
    logic [31:0] t;
    logic        known;
    quant_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jdq_in_if  sample_ch ();
  jdq_out_if result_ch ();

  joystick_direction_quantizer u_top (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [11:0] p_deadzone;
  logic [5:0]  p_snap;
  logic [15:0] p_interval;
  logic [11:0] p_cx, p_cy;
  logic        p_prev_btn;
  logic [31:0] p_last_time;
  logic [15:0] p_last_angle;
  logic        p_sent_valid;

  quant_t expected_q[$];
  int errors = 0;
  int accepted = 0;
  int received = 0;
  int sends_seen = 0;
  int snaps_seen = 0;
  int idle_cycles = 0;
  logic [31:0] now_ms = 32'd0;

  function automatic logic [15:0] cordic_centideg(longint dx, longint dy);
    longint x, y, z, xs, ys, r;
    int tbl[24] = '{45000000, 26565051, 14036243, 7125016, 3576334, 1789911,
                    895174, 447614, 223811, 111906, 55953, 27976, 13988, 6994,
                    3497, 1749, 874, 437, 219, 109, 55, 27, 14, 7};
    longint cd;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 180000000;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + tbl[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - tbl[i];
      end
    end
    r = z + 270000000;
    while (r >= 360000000) r = r - 360000000;
    while (r < 0) r = r + 360000000;
    cd = (r + 5000) / 10000;
    if (cd >= 36000) cd = cd - 36000;
    return cd[15:0];
  endfunction

  function automatic quant_t quantize_sample(logic [11:0] xs, logic [11:0] ys,
                                             logic btn, logic [31:0] t);
    quant_t q;
    longint dx, dy;
    int w, a;
    q = '0;
    if (btn && !p_prev_btn) begin
      p_cx = xs;
      p_cy = ys;
    end
    dx = longint'(p_cx) - longint'(xs);
    dy = longint'(p_cy) - longint'(ys);
    if ((dx < 0 ? -dx : dx) <= p_deadzone && (dy < 0 ? -dy : dy) <= p_deadzone) begin
      q.is_centred = 1'b1;
    end else begin
      w = 100 * p_snap;
      a = cordic_centideg(dx, dy);
      q.direction = jdq_pkg::DIR_FREE;
      if (a > 36000 - w || a < w) begin
        a = 0;
        q.direction = jdq_pkg::DIR_UP;
      end else if (a > 9000 - w && a < 9000 + w) begin
        a = 9000;
        q.direction = jdq_pkg::DIR_RIGHT;
      end else if (a > 18000 - w && a < 18000 + w) begin
        a = 18000;
        q.direction = jdq_pkg::DIR_DOWN;
      end else if (a > 27000 - w && a < 27000 + w) begin
        a = 27000;
        q.direction = jdq_pkg::DIR_LEFT;
      end
      q.angle_centideg = a[15:0];
      if (32'(t - p_last_time) >= {16'd0, p_interval}) begin
        p_last_time = t;
        if (!p_sent_valid || q.angle_centideg != p_last_angle) begin
          q.send_now = 1'b1;
          p_last_angle = q.angle_centideg;
          p_sent_valid = 1'b1;
        end
      end
    end
    p_prev_btn = btn;
    return q;
  endfunction

  // Receiver: stalls on its own pattern and checks every transfer.
  logic [3:0] stall_phase = '0;
  logic       stall_mode = 1'b0;
  initial result_ch.ready = 1'b0;
  always @(posedge clk) begin
    quant_t got, want;
    if (!rst) begin
      stall_phase <= stall_phase + 4'd1;
      if (stall_phase == 4'd15) stall_mode <= ($urandom_range(0, 1) != 0);
      result_ch.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.is_centred, result_ch.direction,
                result_ch.angle_centideg, result_ch.send_now};
        received++;
        if (got.send_now) sends_seen++;
        if (got.direction != jdq_pkg::DIR_FREE) snaps_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.is_centred !== want.is_centred) begin
            $error("is_centred exp %0d got %0d", want.is_centred, got.is_centred);
            errors++;
          end
          if (got.direction !== want.direction) begin
            $error("direction exp %0d got %0d", want.direction, got.direction);
            errors++;
          end
          if (got.angle_centideg !== want.angle_centideg) begin
            $error("angle_centideg exp %0d got %0d", want.angle_centideg,
                   got.angle_centideg);
            errors++;
          end
          if (got.send_now !== want.send_now) begin
            $error("send_now exp %0d got %0d", want.send_now, got.send_now);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_joystick_direction_quantizer failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      jdq_pkg::REG_DEADZONE: p_deadzone = value[11:0];
      jdq_pkg::REG_SNAP:     p_snap = value[5:0];
      default:               p_interval = value[15:0];
    endcase
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Offers one sample and holds it until the block takes it.
  task automatic send_sample(logic [11:0] xs, logic [11:0] ys, logic btn,
                             logic [31:0] t);
    sample_ch.valid <= 1'b1;
    sample_ch.x_sample <= xs;
    sample_ch.y_sample <= ys;
    sample_ch.button_level <= btn;
    sample_ch.time_ms <= t;
    do @(posedge clk); while (!sample_ch.ready);
    expected_q.push_back(quantize_sample(xs, ys, btn, t));
    accepted++;
  endtask

  task automatic end_burst();
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_phase(int count);
    int burst;
    logic [11:0] xs, ys;
    int r, cx, cy, rad;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      cx = p_cx;
      cy = p_cy;
      if (r < 5) begin
        rad = $urandom_range(0, 300);
        xs = 12'(cx + $urandom_range(0, 2 * rad) - rad);
        ys = 12'(cy + $urandom_range(0, 2 * rad) - rad);
      end else if (r < 7) begin
        xs = 12'(cx + $urandom_range(0, 200) - 100);
        ys = 12'($urandom);
      end else begin
        xs = 12'($urandom);
        ys = 12'($urandom);
      end
      now_ms = ($urandom_range(0, 30) == 0) ? $urandom : now_ms + $urandom_range(0, 300);
      send_sample(xs, ys, ($urandom_range(0, 15) == 0), now_ms);
      if (burst == 0) begin
        end_burst();
        burst = $urandom_range(1, 20);
      end else begin
        burst--;
      end
    end
    sample_ch.valid <= 1'b0;
  endtask

  stim_row_t directed[] = '{
    '{12'd2047, 12'd2047, 1'b0, 32'd0,   1'b1,
      '{1'b1, jdq_pkg::DIR_FREE, 16'd0, 1'b0}},
    '{12'd2047, 12'd0,    1'b0, 32'd600, 1'b1,
      '{1'b0, jdq_pkg::DIR_UP, 16'd0, 1'b1}},
    '{12'd2047, 12'd4095, 1'b0, 32'd700, 1'b1,
      '{1'b0, jdq_pkg::DIR_DOWN, 16'd18000, 1'b0}},
    '{12'd2047, 12'd4095, 1'b0, 32'd1200, 1'b1,
      '{1'b0, jdq_pkg::DIR_DOWN, 16'd18000, 1'b1}},
    '{12'd0,    12'd2047, 1'b0, 32'd1800, 1'b1,
      '{1'b0, jdq_pkg::DIR_LEFT, 16'd27000, 1'b1}},
    '{12'd4095, 12'd2047, 1'b0, 32'd2400, 1'b1,
      '{1'b0, jdq_pkg::DIR_RIGHT, 16'd9000, 1'b1}},
    '{12'd4095, 12'd4095, 1'b0, 32'd3000, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 32'd3600, 1'b0, '0},
    '{12'd0,    12'd4095, 1'b0, 32'd3601, 1'b0, '0},
    '{12'd4095, 12'd0,    1'b0, 32'hFFFF_FF00, 1'b0, '0},
    '{12'd1997, 12'd2097, 1'b0, 32'd50,  1'b1,
      '{1'b1, jdq_pkg::DIR_FREE, 16'd0, 1'b0}},
    '{12'd1996, 12'd2047, 1'b0, 32'd700, 1'b0, '0},
    '{12'd4095, 12'd4095, 1'b1, 32'd1300, 1'b1,
      '{1'b1, jdq_pkg::DIR_FREE, 16'd0, 1'b0}},
    '{12'd0,    12'd0,    1'b1, 32'd1900, 1'b0, '0},
    '{12'd0,    12'd0,    1'b0, 32'd2500, 1'b0, '0},
    '{12'd0,    12'd0,    1'b1, 32'd3100, 1'b1,
      '{1'b1, jdq_pkg::DIR_FREE, 16'd0, 1'b0}},
    '{12'd2047, 12'd2047, 1'b0, 32'd3700, 1'b0, '0},
    '{12'd2900, 12'd1200, 1'b0, 32'd4300, 1'b0, '0}
  };

  initial begin
    quant_t pred;
    sample_ch.valid = 1'b0;
    sample_ch.x_sample = '0;
    sample_ch.y_sample = '0;
    sample_ch.button_level = 1'b0;
    sample_ch.time_ms = '0;
    p_deadzone = jdq_pkg::DEADZONE_RESET;
    p_snap = jdq_pkg::SNAP_RESET;
    p_interval = jdq_pkg::INTERVAL_RESET;
    p_cx = 12'd2047;
    p_cy = 12'd2047;
    p_prev_btn = 1'b0;
    p_last_time = '0;
    p_last_angle = '0;
    p_sent_valid = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_sample(directed[i].x, directed[i].y, directed[i].btn, directed[i].t);
      if (directed[i].known) begin
        pred = expected_q[$];
        if (pred !== directed[i].res) begin
          $error("directed row %0d: predictor %h table %h", i, pred, directed[i].res);
          errors++;
        end
      end
      if (i % 4 == 3) end_burst();
    end
    sample_ch.valid <= 1'b0;
    drain_results();

    write_reg(jdq_pkg::REG_SNAP, 32'd0);
    write_reg(jdq_pkg::REG_INTERVAL, 32'd0);
    write_reg(jdq_pkg::REG_DEADZONE, 32'd0);
    random_phase(300);
    drain_results();

    write_reg(jdq_pkg::REG_SNAP, 32'd45);
    write_reg(jdq_pkg::REG_INTERVAL, 32'd65535);
    write_reg(jdq_pkg::REG_DEADZONE, 32'd4095);
    random_phase(100);
    drain_results();

    write_reg(jdq_pkg::REG_DEADZONE, 32'd20);
    write_reg(jdq_pkg::REG_INTERVAL, 32'd100);
    write_reg(jdq_pkg::REG_SNAP, 32'd44);
    random_phase(300);
    drain_results();

    write_reg(jdq_pkg::REG_DEADZONE, $urandom_range(0, 400));
    write_reg(jdq_pkg::REG_SNAP, $urandom_range(1, 20));
    write_reg(jdq_pkg::REG_INTERVAL, $urandom_range(0, 400));
    random_phase(300);
    drain_results();

    write_reg(jdq_pkg::REG_DEADZONE, 32'(jdq_pkg::DEADZONE_RESET));
    write_reg(jdq_pkg::REG_SNAP, 32'(jdq_pkg::SNAP_RESET));
    write_reg(jdq_pkg::REG_INTERVAL, 32'(jdq_pkg::INTERVAL_RESET));
    random_phase(300);
    drain_results();

    $display("Covered %0d samples, %0d results, %0d send flags, %0d cardinal snaps.",
             accepted, received, sends_seen, snaps_seen);
    if (errors == 0) begin
      $display("tb_joystick_direction_quantizer passed");
    end else begin
      $display("tb_joystick_direction_quantizer failed");
    end
    $finish;
  end
endmodule
